### rtl/core/sorted_array_table_engine_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted array table engine
// Concurrent checks that compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_TABLE_ENGINE_UNIT_DEFINES_SVH
`define SORTED_ARRAY_TABLE_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define SATU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("satu: same-cycle check failed");
// Next-cycle implication
`define SATU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("satu: next-cycle check failed");
`else
`define SATU_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SATU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/satu_pkg.sv
// ----------------------------------------------------------------------------
// satu_pkg
// Shared constants, codes and types of the sorted array table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package satu_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int ACTION_W = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 3;
  localparam int FPOS_W   = 5;
  localparam int COUNT_W  = 5;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_DISPLAY = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_DELETE  = 3'd2,
    ACT_SEARCH  = 3'd3,
    ACT_REVERSE = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_INVALID  = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DSP_EMIT,
    S_INS_CHK,
    S_INS_PUT,
    S_DEL_WR,
    S_SRC_CHK,
    S_RV_HI,
    S_RV_WLO,
    S_RV_WHI,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [FPOS_W-1:0]        found_position;
    logic signed [DATA_W-1:0] element;
    logic [COUNT_W-1:0]       count;
    logic                     last;
  } res_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
  } mem_req_t;

endpackage

`default_nettype wire

### rtl/core/satu_stream_if.sv
// ----------------------------------------------------------------------------
// satu_stream_if
// Valid/ready channels for requests and results of the table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface satu_in_if;
  import satu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACTION_W-1:0]      action;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface

interface satu_out_if;
  import satu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [FPOS_W-1:0]        found_position;
  logic signed [DATA_W-1:0] element;
  logic [COUNT_W-1:0]       count;
  logic                     last;

  modport source (output valid, status, found_position, element, count, last, input ready);
  modport sink   (input valid, status, found_position, element, count, last, output ready);
endinterface

`default_nettype wire

### rtl/core/satu_ram.sv
// ----------------------------------------------------------------------------
// satu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module satu_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/satu_ctrl.sv
// ----------------------------------------------------------------------------
// satu_ctrl
// Sequencer that walks the element RAM for each table action.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_array_table_engine_unit_defines.svh"

module satu_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire satu_pkg::in_item_t         in_item,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output satu_pkg::res_t                  res,
  output satu_pkg::mem_req_t              mem_req,
  input  wire logic [satu_pkg::DATA_W-1:0] mem_rd_data
);
  import satu_pkg::*;

  localparam int EXT_W = CNT_W + 1;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [IDX_W-1:0]         i_r, i_nxt;
  logic [IDX_W-1:0]         hi_r, hi_nxt;
  logic [DATA_W-1:0]        tmp_r, tmp_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic [FPOS_W-1:0]        fpos_r, fpos_nxt;

  logic                     accept;
  logic                     is_empty, is_full, del_bad, del_more_first;
  logic                     dsp_more, ins_gt, ins_more, del_more, src_hit, src_more, rv_more;
  logic [CMP_W-1:0]         pos_ext, n_ext;
  logic [EXT_W-1:0]         i_ext, hi_ext, cnt_ext;
  logic signed [DATA_W-1:0] rd_s;

  // Decode flags shared by the next-state and datapath logic
  always_comb begin
    accept         = in_valid && in_ready;
    pos_ext        = CMP_W'(in_item.position);
    n_ext          = CMP_W'(count_r);
    i_ext          = EXT_W'(i_r);
    hi_ext         = EXT_W'(hi_r);
    cnt_ext        = EXT_W'(count_r);
    rd_s           = $signed(mem_rd_data);
    is_empty       = (count_r == '0);
    is_full        = (count_r >= CNT_W'(CAPACITY));
    del_bad        = (pos_ext == '0) || (pos_ext > n_ext);
    del_more_first = (pos_ext < n_ext);
    dsp_more       = (i_ext + EXT_W'(1)) < cnt_ext;
    ins_gt         = rd_s > value_r;
    ins_more       = (i_r > IDX_W'(1));
    del_more       = (i_ext + EXT_W'(2)) < cnt_ext;
    src_hit        = (rd_s == value_r);
    src_more       = (i_ext + EXT_W'(1)) < cnt_ext;
    rv_more        = (i_ext + EXT_W'(2)) < hi_ext;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.action)
            ACT_DISPLAY: state_nxt = is_empty ? S_RESP : S_DSP_EMIT;
            ACT_INSERT: begin
              if (is_full) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = is_empty ? S_INS_PUT : S_INS_CHK;
              end
            end
            ACT_DELETE: begin
              if (is_empty || del_bad || !del_more_first) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_DEL_WR;
              end
            end
            ACT_SEARCH: state_nxt = is_empty ? S_RESP : S_SRC_CHK;
            ACT_REVERSE: begin
              state_nxt = (count_r > CNT_W'(1)) ? S_RV_HI : S_RESP;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_DSP_EMIT: begin
        if (res_ready && !dsp_more) begin
          state_nxt = S_IDLE;
        end
      end
      S_INS_CHK: begin
        if (ins_gt) begin
          state_nxt = ins_more ? S_INS_CHK : S_INS_PUT;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_INS_PUT: state_nxt = S_RESP;
      S_DEL_WR:  state_nxt = del_more ? S_DEL_WR : S_RESP;
      S_SRC_CHK: state_nxt = (!src_hit && src_more) ? S_SRC_CHK : S_RESP;
      S_RV_HI:   state_nxt = S_RV_WLO;
      S_RV_WLO:  state_nxt = S_RV_WHI;
      S_RV_WHI:  state_nxt = rv_more ? S_RV_HI : S_RESP;
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory requests and handshake outputs
  always_comb begin
    in_ready   = (state_r == S_IDLE);
    res_valid  = 1'b0;
    res        = '0;
    mem_req    = '0;
    count_nxt  = count_r;
    value_nxt  = value_r;
    i_nxt      = i_r;
    hi_nxt     = hi_r;
    tmp_nxt    = tmp_r;
    status_nxt = status_r;
    fpos_nxt   = fpos_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          value_nxt  = in_item.value;
          fpos_nxt   = '0;
          status_nxt = ST_OK;
          case (in_item.action)
            ACT_DISPLAY: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                i_nxt           = '0;
              end
            end
            ACT_INSERT: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                i_nxt = IDX_W'(count_r);
                if (!is_empty) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = IDX_W'(count_r - CNT_W'(1));
                end
              end
            end
            ACT_DELETE: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else if (del_bad) begin
                status_nxt = ST_INVALID;
              end else begin
                i_nxt = IDX_W'(pos_ext - CMP_W'(1));
                if (del_more_first) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = IDX_W'(pos_ext);
                end else begin
                  // Last entry: drop it without moving anything
                  count_nxt = count_r - CNT_W'(1);
                end
              end
            end
            ACT_SEARCH: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                i_nxt           = '0;
              end
            end
            ACT_REVERSE: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else if (count_r > CNT_W'(1)) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                i_nxt           = '0;
                hi_nxt          = IDX_W'(count_r - CNT_W'(1));
              end
            end
            default: status_nxt = ST_INVALID;
          endcase
        end
      end
      S_DSP_EMIT: begin
        res_valid     = 1'b1;
        res.status    = ST_OK;
        res.element   = rd_s;
        res.count     = COUNT_W'(count_r);
        res.last      = !dsp_more;
        if (res_ready && dsp_more) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = i_r + IDX_W'(1);
          i_nxt           = i_r + IDX_W'(1);
        end
      end
      S_INS_CHK: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = i_r;
        if (ins_gt) begin
          // Shift the larger element up one place and keep walking back
          mem_req.wr_data = mem_rd_data;
          i_nxt           = i_r - IDX_W'(1);
          if (ins_more) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = i_r - IDX_W'(2);
          end
        end else begin
          mem_req.wr_data = value_r;
          count_nxt       = count_r + CNT_W'(1);
          status_nxt      = ST_OK;
        end
      end
      S_INS_PUT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = i_r;
        mem_req.wr_data = value_r;
        count_nxt       = count_r + CNT_W'(1);
        status_nxt      = ST_OK;
      end
      S_DEL_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = i_r;
        mem_req.wr_data = mem_rd_data;
        if (del_more) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = i_r + IDX_W'(2);
          i_nxt           = i_r + IDX_W'(1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      S_SRC_CHK: begin
        if (src_hit) begin
          status_nxt = ST_OK;
          fpos_nxt   = FPOS_W'(i_ext + EXT_W'(1));
        end else if (src_more) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = i_r + IDX_W'(1);
          i_nxt           = i_r + IDX_W'(1);
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      S_RV_HI: begin
        tmp_nxt         = mem_rd_data;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = hi_r;
      end
      S_RV_WLO: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = i_r;
        mem_req.wr_data = mem_rd_data;
      end
      S_RV_WHI: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = hi_r;
        mem_req.wr_data = tmp_r;
        if (rv_more) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = i_r + IDX_W'(1);
          i_nxt           = i_r + IDX_W'(1);
          hi_nxt          = hi_r - IDX_W'(1);
        end
      end
      S_RESP: begin
        res_valid          = 1'b1;
        res.status         = status_r;
        res.found_position = fpos_r;
        res.count          = COUNT_W'(count_r);
        res.last           = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    i_r      <= i_nxt;
    hi_r     <= hi_nxt;
    tmp_r    <= tmp_nxt;
    status_r <= status_nxt;
    fpos_r   <= fpos_nxt;
  end

  `SATU_ASSERT_IMPLY(a_count_cap, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SATU_ASSERT_IMPLY(a_wr_range, clk, rst_n, mem_req.wr_en, CNT_W'(mem_req.wr_addr) <= count_r)
  `SATU_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, state_r != S_IDLE)
  `SATU_ASSERT_IMPLY(a_partial_dsp, clk, rst_n, res_valid && !res.last, state_r == S_DSP_EMIT)

endmodule

`default_nettype wire

### rtl/core/sorted_array_table_engine_unit.sv
// ----------------------------------------------------------------------------
// sorted_array_table_engine_unit
// Ordered table of signed 32-bit values with insert, delete, search,
// reverse and display actions.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request transaction (action, value, position); out_ch
//   carries result transactions (status, found_position, element, count,
//   last). Every request gives one result, except display of a non-empty
//   table, which gives one result per element with last on the final one.
//   Requests are taken one at a time: in_ch.ready is high only while the
//   sequencer is idle. Each request is worked step by step through the
//   single read port of the element RAM, whose read data is registered;
//   display also waits on receiver stalls between its elements.
//   Results leave through an output register, so the sequencer moves on
//   while a result waits; when out_ch.ready is low the register holds and
//   the sequencer stalls on its next result.
//   Reset (rst_n low, synchronous) empties the table at once; no clearing
//   pass runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_table_engine_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  satu_in_if.sink    in_ch,
  satu_out_if.source out_ch
);
  import satu_pkg::*;

  in_item_t          in_item;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rd_data;

  logic              out_valid_r, out_valid_nxt;
  res_t              out_data_r, out_data_nxt;

  always_comb begin
    in_item.action   = in_ch.action;
    in_item.value    = in_ch.value;
    in_item.position = in_ch.position;
  end

  satu_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_rd_data)
  );

  satu_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_item     (in_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  // Output register: load when empty or draining this cycle
  always_comb begin
    res_ready     = !out_valid_r || out_ch.ready;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_data_r.status;
  assign out_ch.found_position = out_data_r.found_position;
  assign out_ch.element        = out_data_r.element;
  assign out_ch.count          = out_data_r.count;
  assign out_ch.last           = out_data_r.last;

endmodule

`default_nettype wire

### tb/sv/satu_table_checker.sv
// ----------------------------------------------------------------------------
// satu_table_checker
// Watches both channels of the table engine, keeps a shadow copy of the
// ordered table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module satu_table_checker
  import satu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [ACTION_W-1:0]      in_action,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_position,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  res_t                     out_result,
  output int                       mismatches,
  output int                       pending_results,
  output int                       results_checked
);

  logic signed [DATA_W-1:0] shadow_tbl [CAPACITY];
  int                       shadow_fill;
  res_t                     expected_results [$];
  int                       err_cnt;
  int                       seen_cnt;

  initial begin
    mismatches      = 0;
    pending_results = 0;
    results_checked = 0;
    err_cnt         = 0;
    seen_cnt        = 0;
    shadow_fill     = 0;
  end

  function automatic void queue_result(status_t st, logic [FPOS_W-1:0] fpos,
                                       logic signed [DATA_W-1:0] elem, logic lst);
    res_t r;
    r.status         = st;
    r.found_position = fpos;
    r.element        = elem;
    r.count          = COUNT_W'(shadow_fill);
    r.last           = lst;
    expected_results.push_back(r);
  endfunction

  // Apply one request to the shadow table and queue the results it causes.
  function automatic void apply_request(logic [ACTION_W-1:0] act,
                                        logic signed [DATA_W-1:0] val,
                                        logic [POS_W-1:0] pos);
    int                       k;
    int                       hit;
    logic signed [DATA_W-1:0] tmp;
    case (act)
      ACT_DISPLAY: begin
        if (shadow_fill == 0) begin
          queue_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (k = 0; k < shadow_fill; k++)
            queue_result(ST_OK, '0, shadow_tbl[k], k == shadow_fill - 1);
        end
      end
      ACT_INSERT: begin
        if (shadow_fill >= CAPACITY) begin
          queue_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          // shift larger entries up; equal ones stay ahead of the new value
          k = shadow_fill;
          while (k > 0 && shadow_tbl[k-1] > val) begin
            shadow_tbl[k] = shadow_tbl[k-1];
            k--;
          end
          shadow_tbl[k] = val;
          shadow_fill++;
          queue_result(ST_OK, '0, '0, 1'b1);
        end
      end
      ACT_DELETE: begin
        if (shadow_fill == 0) begin
          queue_result(ST_EMPTY, '0, '0, 1'b1);
        end else if (pos < 1 || pos > shadow_fill) begin
          queue_result(ST_INVALID, '0, '0, 1'b1);
        end else begin
          for (k = pos - 1; k + 1 < shadow_fill; k++)
            shadow_tbl[k] = shadow_tbl[k+1];
          shadow_fill--;
          queue_result(ST_OK, '0, '0, 1'b1);
        end
      end
      ACT_SEARCH: begin
        if (shadow_fill == 0) begin
          queue_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          hit = 0;
          for (k = 0; k < shadow_fill; k++)
            if (hit == 0 && shadow_tbl[k] == val) hit = k + 1;
          if (hit != 0) queue_result(ST_OK, FPOS_W'(hit), '0, 1'b1);
          else queue_result(ST_NOTFOUND, '0, '0, 1'b1);
        end
      end
      ACT_REVERSE: begin
        if (shadow_fill == 0) begin
          queue_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (k = 0; k < shadow_fill / 2; k++) begin
            tmp                           = shadow_tbl[k];
            shadow_tbl[k]                 = shadow_tbl[shadow_fill-1-k];
            shadow_tbl[shadow_fill-1-k]   = tmp;
          end
          queue_result(ST_OK, '0, '0, 1'b1);
        end
      end
      default: queue_result(ST_INVALID, '0, '0, 1'b1);
    endcase
  endfunction

  function automatic bit field_differs(string tag, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d (0x%h) actual %0d (0x%h)",
               $time, tag, $signed(want), want, $signed(got), got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void check_result(res_t got);
    res_t want;
    bit   bad;
    if (expected_results.size() == 0) begin
      $display("%0t ns: unexpected result, expected none, actual status %0d element %0d",
               $time, got.status, got.element);
      err_cnt++;
      return;
    end
    want = expected_results.pop_front();
    bad  = field_differs("status", DATA_W'(want.status), DATA_W'(got.status))
         | field_differs("found_position", DATA_W'(want.found_position),
                         DATA_W'(got.found_position))
         | field_differs("element", want.element, got.element)
         | field_differs("count", DATA_W'(want.count), DATA_W'(got.count))
         | field_differs("last", DATA_W'(want.last), DATA_W'(got.last));
    if (bad) err_cnt++;
    seen_cnt++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      shadow_fill = 0;
    end else begin
      // a result can never belong to a request taken on the same edge
      if (out_valid && out_ready) check_result(out_result);
      if (in_valid && in_ready) apply_request(in_action, in_value, in_position);
    end
    mismatches      <= err_cnt;
    pending_results <= expected_results.size();
    results_checked <= seen_cnt;
  end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the sorted array table engine under changing idle and
// stall mixes, with one long output hold, and reports the checker verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import satu_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int PHASE_ITEMS   = 28;
  localparam int PRESSURE_ITEMS = 8;

  localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_req       = 1'b0;
  int  stim_fill      = 0;
  int  requests_sent  = 0;
  logic signed [DATA_W-1:0] recent_value = '0;

  int mismatches;
  int pending_results;
  int results_checked;

  int idle_by_phase  [4] = '{0, 79, 0, 28};
  int stall_by_phase [4] = '{0, 0, 79, 28};

  always #(HALF_PERIOD) clk = ~clk;

  satu_in_if  in_ch ();
  satu_out_if out_ch ();

  sorted_array_table_engine_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  satu_table_checker i_table_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_action       (in_ch.action),
    .in_value        (in_ch.value),
    .in_position     (in_ch.position),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_result      ({out_ch.status, out_ch.found_position, out_ch.element,
                       out_ch.count, out_ch.last}),
    .mismatches      (mismatches),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  // Offer one request and hold it until the engine takes it.
  task automatic send_request(logic [ACTION_W-1:0] act, logic signed [DATA_W-1:0] val,
                              logic [POS_W-1:0] pos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.value    <= val;
    in_ch.position <= pos;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
    if (act == ACT_INSERT && stim_fill < CAPACITY) begin
      stim_fill++;
      recent_value = val;
    end
    if (act == ACT_DELETE && pos >= 1 && pos <= stim_fill) stim_fill--;
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom_range(31));
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return recent_value;
      2: begin
        case ($urandom_range(3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return $urandom_range(10) - 5;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_delete_pos();
    if (stim_fill > 0 && $urandom_range(9) < 8) return POS_W'($urandom_range(stim_fill, 1));
    return rand_pos();
  endfunction

  task automatic random_request();
    int r;
    r = $urandom_range(99);
    if (r < 35)      send_request(ACT_INSERT, pick_value(), rand_pos());
    else if (r < 55) send_request(ACT_DELETE, $urandom, pick_delete_pos());
    else if (r < 75) send_request(ACT_SEARCH, pick_value(), rand_pos());
    else if (r < 85) send_request(ACT_REVERSE, $urandom, rand_pos());
    else if (r < 95) send_request(ACT_DISPLAY, $urandom, rand_pos());
    else send_request(ACTION_W'($urandom_range(ACT_UNDEF_HI, ACT_UNDEF_LO)), $urandom,
                      rand_pos());
  endtask

  // One well-formed sequence: fill to the top, drain to empty, or a mixed run.
  task automatic run_episode();
    int kind;
    kind = $urandom_range(2);
    if (stim_fill < 4 && $urandom_range(1)) kind = 0;
    case (kind)
      0: begin
        while (stim_fill < CAPACITY)
          send_request(ACT_INSERT, pick_value(), rand_pos());
        send_request(ACT_INSERT, pick_value(), rand_pos());
        send_request(ACT_DISPLAY, $urandom, rand_pos());
        send_request(ACT_SEARCH, recent_value, rand_pos());
      end
      1: begin
        while (stim_fill > 0) begin
          send_request(ACT_DELETE, $urandom, pick_delete_pos());
          if ($urandom_range(3) == 0) send_request(ACT_SEARCH, pick_value(), rand_pos());
          if ($urandom_range(5) == 0) send_request(ACT_REVERSE, $urandom, rand_pos());
        end
        send_request(ACT_DELETE, $urandom, rand_pos());
        send_request(ACT_DISPLAY, $urandom, rand_pos());
      end
      default: repeat (10) random_request();
    endcase
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t ns: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int phase_start;
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_DISPLAY;
    in_ch.value    = '0;
    in_ch.position = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table on display, delete, search and reverse, then an unused code
    send_request(ACT_DISPLAY, '0, '0);
    send_request(ACT_DELETE, '0, 5'd5);
    send_request(ACT_SEARCH, '0, '0);
    send_request(ACT_REVERSE, '0, '0);
    send_request(ACT_UNDEF_LO, '0, '0);
    // extremes and duplicates, equal values keep arrival order
    send_request(ACT_INSERT, '0, '0);
    send_request(ACT_INSERT, VAL_MAX, 5'd31);
    send_request(ACT_INSERT, VAL_MIN, '0);
    send_request(ACT_INSERT, -1, '0);
    send_request(ACT_INSERT, '0, '0);
    send_request(ACT_INSERT, 32'sd7, '0);
    send_request(ACT_DISPLAY, '0, '0);
    send_request(ACT_SEARCH, '0, '0);
    send_request(ACT_SEARCH, VAL_MAX, '0);
    send_request(ACT_SEARCH, 32'sd12345, '0);
    // delete: position zero, far beyond count, just past count, last, first
    send_request(ACT_DELETE, '0, 5'd0);
    send_request(ACT_DELETE, '0, 5'd31);
    send_request(ACT_DELETE, '0, 5'd7);
    send_request(ACT_DELETE, '0, 5'd6);
    send_request(ACT_DELETE, '0, 5'd1);
    send_request(ACT_REVERSE, '0, '0);
    send_request(ACT_DISPLAY, '0, '0);
    send_request(ACT_UNDEF_HI, VAL_MIN, 5'd31);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      phase_start    = requests_sent;
      while (requests_sent - phase_start < PHASE_ITEMS) run_episode();
      if (p == 0) begin
        // back up the output so the engine stops taking requests
        hold_req = 1'b1;
        repeat (PRESSURE_ITEMS) random_request();
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests over four idle/stall mixes and a %0d-cycle output hold",
             requests_sent, HOLD_CYCLES);
    $display("%0d results compared, %0d mismatching", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/satu_pkg.sv
rtl/core/satu_stream_if.sv
rtl/core/satu_ram.sv
rtl/core/satu_ctrl.sv
rtl/core/sorted_array_table_engine_unit.sv
tb/sv/satu_table_checker.sv
tb/sv/testbench.sv
